// ===== rtl/core/hkta_pkg.sv =====
// Shared types, constants and character tables of the HID keyboard to ASCII block.
// Used by the interfaces and by every module under rtl/core.
package hkta_pkg;

	localparam int KEY_SLOTS     = 6;
	localparam int KEY_MAX_USAGE = 100;
	localparam int KEY_W         = 7;
	localparam int COUNT_W       = $clog2(KEY_SLOTS + 1);
	localparam int PAGE_W        = 16;
	localparam int USAGE_W       = 16;
	localparam int VALUE_W       = 32;
	localparam int CHAR_W        = 8;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CHAR_W-1:0] CODE_ILLEGAL = 8'hff;
	localparam logic [CHAR_W-1:0] CODE_ERASE   = 8'h7f;

	localparam logic [PAGE_W-1:0]  RESET_KEYBOARD_PAGE = 16'h0007;
	localparam logic [USAGE_W-1:0] RESET_SHIFT_USAGE_A = 16'h00e1;
	localparam logic [USAGE_W-1:0] RESET_SHIFT_USAGE_B = 16'h00e6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEYBOARD_PAGE = 2'd0,
		REG_SHIFT_USAGE_A = 2'd1,
		REG_SHIFT_USAGE_B = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  keyboard_page;
		logic [USAGE_W-1:0] shift_usage_a;
		logic [USAGE_W-1:0] shift_usage_b;
	} cfg_t;

	typedef struct packed {
		logic [PAGE_W-1:0]         hid_page;
		logic [USAGE_W-1:0]        usage;
		logic signed [VALUE_W-1:0] field_value;
		logic                      last_field;
	} field_t;

	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] char_code;
		logic              erase;
	} result_t;

	// Codes shared by both layers: control keys and the keypad.
	function automatic logic [CHAR_W-1:0] common_char(input logic [KEY_W-1:0] key);
		logic [CHAR_W-1:0] c;
		c = CODE_ILLEGAL;
		if (key >= 7'd89 && key <= 7'd97) begin
			c = 8'h31 + CHAR_W'(key - 7'd89);
		end else begin
			case (key)
				7'd40:   c = 8'h0a;
				7'd41:   c = 8'h1b;
				7'd42:   c = 8'h7f;
				7'd43:   c = 8'h09;
				7'd44:   c = 8'h20;
				7'd85:   c = 8'h2a;
				7'd86:   c = 8'h2d;
				7'd87:   c = 8'h2b;
				7'd88:   c = 8'h0a;
				7'd98:   c = 8'h30;
				7'd99:   c = 8'h2e;
				default: c = CODE_ILLEGAL;
			endcase
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_W-1:0] key);
		logic [CHAR_W-1:0] c;
		c = common_char(key);
		if (key >= 7'd4 && key <= 7'd29) begin
			c = 8'h61 + CHAR_W'(key - 7'd4);
		end else if (key >= 7'd30 && key <= 7'd38) begin
			c = 8'h31 + CHAR_W'(key - 7'd30);
		end else begin
			case (key)
				7'd39:   c = 8'h30;
				7'd45:   c = 8'h2d;
				7'd46:   c = 8'h3d;
				7'd47:   c = 8'h5b;
				7'd48:   c = 8'h5d;
				7'd49:   c = 8'h5c;
				7'd51:   c = 8'h3b;
				7'd52:   c = 8'h27;
				7'd53:   c = 8'h60;
				7'd54:   c = 8'h2c;
				7'd55:   c = 8'h2e;
				7'd56:   c = 8'h2f;
				7'd100:  c = 8'ha7;
				default: c = common_char(key);
			endcase
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] shifted_char(input logic [KEY_W-1:0] key);
		logic [CHAR_W-1:0] c;
		c = common_char(key);
		if (key >= 7'd4 && key <= 7'd29) begin
			c = 8'h41 + CHAR_W'(key - 7'd4);
		end else begin
			case (key)
				7'd30:   c = 8'h21;
				7'd31:   c = 8'h40;
				7'd32:   c = 8'h23;
				7'd33:   c = 8'h24;
				7'd34:   c = 8'h25;
				7'd35:   c = 8'h5e;
				7'd36:   c = 8'h26;
				7'd37:   c = 8'h2a;
				7'd38:   c = 8'h28;
				7'd39:   c = 8'h29;
				7'd45:   c = 8'h5f;
				7'd46:   c = 8'h2b;
				7'd47:   c = 8'h7b;
				7'd48:   c = 8'h7d;
				7'd49:   c = 8'h7c;
				7'd51:   c = 8'h3a;
				7'd52:   c = 8'h22;
				7'd53:   c = 8'h7e;
				7'd54:   c = 8'h3c;
				7'd55:   c = 8'h3e;
				7'd56:   c = 8'h3f;
				7'd100:  c = 8'hb1;
				default: c = common_char(key);
			endcase
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/hkta_if.sv =====
// Valid/ready channel interfaces for report fields and for characters.
// Depends on hkta_pkg for the field widths.
interface hkta_field_if;
	import hkta_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [PAGE_W-1:0]         hid_page;
	logic [USAGE_W-1:0]        usage;
	logic signed [VALUE_W-1:0] field_value;
	logic                      last_field;

	modport source (output valid, hid_page, usage, field_value, last_field, input ready);
	modport sink (input valid, hid_page, usage, field_value, last_field, output ready);
endinterface

interface hkta_char_if;
	import hkta_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              erase;

	modport source (output valid, char_code, erase, input ready);
	modport sink (input valid, char_code, erase, output ready);
endinterface

// ===== rtl/core/hkta_cfg.sv =====
// Configuration registers: keyboard page and the two shift usages.
// Depends on hkta_pkg.
module hkta_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wen,
	input  logic [hkta_pkg::CFG_IDX_W-1:0] index,
	input  logic [hkta_pkg::USAGE_W-1:0]   wdata,
	output hkta_pkg::cfg_t                 cfg
);
	import hkta_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keyboard_page <= RESET_KEYBOARD_PAGE;
			cfg_q.shift_usage_a <= RESET_SHIFT_USAGE_A;
			cfg_q.shift_usage_b <= RESET_SHIFT_USAGE_B;
		end else if (wen) begin
			case (cfg_reg_t'(index))
				REG_KEYBOARD_PAGE: cfg_q.keyboard_page <= wdata;
				REG_SHIFT_USAGE_A: cfg_q.shift_usage_a <= wdata;
				REG_SHIFT_USAGE_B: cfg_q.shift_usage_b <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== rtl/core/hkta_decode.sv =====
// Key state of the current and previous report, and the mapping of one field to a character.
// Depends on hkta_pkg.
module hkta_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  hkta_pkg::field_t  item,
	input  hkta_pkg::cfg_t    cfg,
	output hkta_pkg::result_t res
);
	import hkta_pkg::*;

	logic [KEY_W-1:0]   held_q [KEY_SLOTS];
	logic [KEY_W-1:0]   report_q [KEY_SLOTS];
	logic [KEY_W-1:0]   report_next [KEY_SLOTS];
	logic [COUNT_W-1:0] count_q;
	logic               shift_q;

	logic               is_page;
	logic               is_shift;
	logic               is_key;
	logic               held_hit;
	logic [KEY_W-1:0]   key;
	logic [CHAR_W-1:0]  code;

	assign key      = item.usage[KEY_W-1:0];
	assign is_page  = item.hid_page == cfg.keyboard_page;
	assign is_shift = is_page && (item.usage == cfg.shift_usage_a ||
	                              item.usage == cfg.shift_usage_b);
	assign is_key   = is_page && !is_shift && item.usage != '0 &&
	                  item.usage <= USAGE_W'(KEY_MAX_USAGE);

	always_comb begin
		held_hit = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (held_q[i] == key) begin
				held_hit = 1'b1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			report_next[i] = (is_key && count_q == COUNT_W'(i)) ? key : report_q[i];
		end
	end

	assign code          = shift_q ? shifted_char(key) : plain_char(key);
	assign res.valid     = is_key && !held_hit && code != CODE_ILLEGAL;
	assign res.char_code = code;
	assign res.erase     = code == CODE_ERASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				held_q[i]   <= '0;
				report_q[i] <= '0;
			end
			count_q <= '0;
			shift_q <= 1'b0;
		end else if (step) begin
			if (item.last_field) begin
				for (int i = 0; i < KEY_SLOTS; i++) begin
					held_q[i]   <= report_next[i];
					report_q[i] <= '0;
				end
				count_q <= '0;
				shift_q <= 1'b0;
			end else begin
				for (int i = 0; i < KEY_SLOTS; i++) begin
					report_q[i] <= report_next[i];
				end
				if (is_key && count_q != COUNT_W'(KEY_SLOTS)) begin
					count_q <= count_q + COUNT_W'(1);
				end
				if (is_shift && item.field_value != '0) begin
					shift_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== rtl/core/hid_keyboard_to_ascii.sv =====
// HID keyboard usage to ASCII converter, US layout, top level.
// Depends on hkta_pkg, hkta_if, hkta_cfg and hkta_decode.
//
// The block takes one parsed report field per cycle and gives at most one character
// for it. A field is caught in an input register and mapped from there, where its
// key is compared with the six held keys and looked up in the character table; the
// result sits in an output register, from which the character is offered. Fields
// are taken back to back as long as the output side takes characters; while a
// character waits, the input register holds one more field and the input then
// stalls until the character is taken.
module hid_keyboard_to_ascii (
	input  logic                           clk,
	input  logic                           arst_n,
	hkta_field_if.sink                     fields,
	hkta_char_if.source                    chars,
	input  logic                           cfg_wen,
	input  logic [hkta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hkta_pkg::USAGE_W-1:0]   cfg_wdata
);
	import hkta_pkg::*;

	cfg_t              cfg;
	field_t            item_s1;
	logic              valid_s1;
	logic              advance;
	result_t           res;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              erase_q;

	assign advance      = valid_s1 && (!out_valid_q || chars.ready);
	assign fields.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fields.ready) begin
			valid_s1 <= fields.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fields.ready && fields.valid) begin
			item_s1.hid_page    <= fields.hid_page;
			item_s1.usage       <= fields.usage;
			item_s1.field_value <= fields.field_value;
			item_s1.last_field  <= fields.last_field;
		end
	end

	hkta_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	hkta_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			char_q  <= res.char_code;
			erase_q <= res.erase;
		end
	end

	assign chars.valid     = out_valid_q;
	assign chars.char_code = char_q;
	assign chars.erase     = erase_q;
endmodule
